// ----- rtl/hpe_pkg.sv -----
// hpe_pkg: shared types and constants of the Horner polynomial evaluator.
// Holds the per-step data word and the configuration register map.
// No dependencies.
`default_nettype none

package hpe_pkg;

	// Q16.16 data word width and number of coefficient registers
	localparam int DATA_W     = 32;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int COEFF_REGS = 7;
	localparam int IDX_W      = 3;

	// Configuration register map
	typedef enum logic [IDX_W-1:0] {
		REG_DEGREE  = 3'd0,
		REG_COEFF_0 = 3'd1,
		REG_COEFF_1 = 3'd2,
		REG_COEFF_2 = 3'd3,
		REG_COEFF_3 = 3'd4,
		REG_COEFF_4 = 3'd5,
		REG_COEFF_5 = 3'd6,
		REG_COEFF_6 = 3'd7
	} cfg_reg_t;

	// Data passed from one Horner step to the next
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] acc;
		logic                     sat;
	} step_t;

endpackage

`default_nettype wire

// ----- rtl/hpe_step.sv -----
// hpe_step: one Horner step (acc = sat(round(acc*x)) + coeff, saturated; zero when inactive)
// in three register stages: multiply, round/shift/clamp, coefficient add/clamp.
// Depends on hpe_pkg.
`default_nettype none

module hpe_step #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                up_valid,
	output logic                                     up_ready,
	input  wire hpe_pkg::step_t                      up_data,
	input  wire logic                                active,
	input  wire logic signed [hpe_pkg::DATA_W-1:0]   coeff,
	output logic                                     dn_valid,
	input  wire logic                                dn_ready,
	output hpe_pkg::step_t                           dn_data
);

	localparam int RND_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
	localparam logic signed [hpe_pkg::PROD_W-1:0] RND =
		(FRAC_BITS > 0) ? (64'sd1 <<< RND_SH) : 64'sd0;
	localparam logic signed [hpe_pkg::PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [hpe_pkg::PROD_W-1:0] S32_MIN = -64'sh0000_0000_8000_0000;
	localparam logic signed [hpe_pkg::DATA_W-1:0] D_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [hpe_pkg::DATA_W-1:0] D_MIN = 32'sh8000_0000;

	logic                                v_s1, v_s2, v_s3;
	logic                                rdy_s1, rdy_s2, rdy_s3;
	logic signed [hpe_pkg::PROD_W-1:0]   prod_s1;
	logic signed [hpe_pkg::DATA_W-1:0]   x_s1, x_s2;
	logic                                sat_s1, sat_s2;
	logic signed [hpe_pkg::DATA_W-1:0]   p_s2;
	hpe_pkg::step_t                      out_s3;

	logic signed [hpe_pkg::PROD_W-1:0]   rnd_sum;
	logic signed [hpe_pkg::PROD_W-1:0]   shifted;
	logic                                p_hi, p_lo;
	logic signed [hpe_pkg::DATA_W-1:0]   p_clamp;
	logic signed [hpe_pkg::DATA_W:0]     add_sum;
	logic                                add_ovf;
	logic signed [hpe_pkg::DATA_W-1:0]   add_clamp;

	// Ready chain: a stage loads when empty or when its successor moves
	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// Round to nearest, floor shift, clamp to 32 bits
	always_comb begin
		rnd_sum = prod_s1 + RND;
		shifted = rnd_sum >>> FRAC_BITS;
		p_hi    = shifted > S32_MAX;
		p_lo    = shifted < S32_MIN;
		if (p_hi) begin
			p_clamp = D_MAX;
		end else if (p_lo) begin
			p_clamp = D_MIN;
		end else begin
			p_clamp = shifted[hpe_pkg::DATA_W-1:0];
		end
	end

	// Coefficient add with saturation; inactive steps keep the sum at zero
	always_comb begin
		add_sum = {p_s2[hpe_pkg::DATA_W-1], p_s2} + {coeff[hpe_pkg::DATA_W-1], coeff};
		add_ovf = add_sum[hpe_pkg::DATA_W] != add_sum[hpe_pkg::DATA_W-1];
		if (add_ovf) begin
			add_clamp = add_sum[hpe_pkg::DATA_W] ? D_MIN : D_MAX;
		end else begin
			add_clamp = add_sum[hpe_pkg::DATA_W-1:0];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: full product
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			prod_s1 <= 64'(up_data.acc) * 64'(up_data.x);
			x_s1    <= up_data.x;
			sat_s1  <= up_data.sat;
		end
	end

	// Stage 2: rounded, clamped product
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			p_s2   <= p_clamp;
			x_s2   <= x_s1;
			sat_s2 <= sat_s1 | p_hi | p_lo;
		end
	end

	// Stage 3: new running sum
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			out_s3.x   <= x_s2;
			out_s3.acc <= active ? add_clamp : '0;
			out_s3.sat <= sat_s2 | (active & add_ovf);
		end
	end

	assign dn_valid = v_s3;
	assign dn_data  = out_s3;

endmodule

`default_nettype wire

// ----- rtl/horner_polynomial_eval_unit.sv -----
// Throughput: one point per cycle unless out_ready stalls it; every Horner step is its
// own three-stage multiply / round / add slice, so the chain is fully pipelined.
// Empty stages collapse, so inputs keep flowing while a result waits.
// Reset (arst_n low) empties the pipeline and clears degree and coefficients to zero.
`default_nettype none

module horner_polynomial_eval_unit #(
	parameter int MAX_TERMS = 7,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [hpe_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [hpe_pkg::DATA_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [hpe_pkg::DATA_W-1:0]   x_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [hpe_pkg::DATA_W-1:0]        poly_value,
	output logic                                     saturated
);

	localparam logic [hpe_pkg::IDX_W-1:0] TOP_MAX = hpe_pkg::IDX_W'(MAX_TERMS - 1);

	logic [hpe_pkg::IDX_W-1:0]            degree_q;
	logic signed [hpe_pkg::DATA_W-1:0]    coeff_q [hpe_pkg::COEFF_REGS];
	logic [hpe_pkg::IDX_W-1:0]            top;
	logic [hpe_pkg::IDX_W-1:0]            coeff_sel;

	hpe_pkg::step_t chain_data  [MAX_TERMS+1];
	logic           chain_valid [MAX_TERMS+1];
	logic           chain_ready [MAX_TERMS+1];

	// Configuration registers
	assign coeff_sel = cfg_index - hpe_pkg::IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int i = 0; i < hpe_pkg::COEFF_REGS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hpe_pkg::REG_DEGREE: begin
					degree_q <= cfg_data[hpe_pkg::IDX_W-1:0];
				end
				default: begin
					coeff_q[coeff_sel] <= cfg_data;
				end
			endcase
		end
	end

	// Effective degree, limited to the pipeline depth
	assign top = (degree_q > TOP_MAX) ? TOP_MAX : degree_q;

	// Pipeline head: sum starts at zero
	assign chain_valid[0]    = in_valid;
	assign in_ready          = chain_ready[0];
	assign chain_data[0].x   = x_value;
	assign chain_data[0].acc = '0;
	assign chain_data[0].sat = 1'b0;

	// Step k handles coefficient index MAX_TERMS-1-k
	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_step
		localparam int J = MAX_TERMS - 1 - k;
		logic active;

		assign active = hpe_pkg::IDX_W'(J) <= top;

		hpe_step #(
			.FRAC_BITS (FRAC_BITS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_data  (chain_data[k]),
			.active   (active),
			.coeff    (coeff_q[J]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_data  (chain_data[k+1])
		);
	end

	// Last step's output register is the result port
	assign out_valid              = chain_valid[MAX_TERMS];
	assign chain_ready[MAX_TERMS] = out_ready;
	assign poly_value             = chain_data[MAX_TERMS].acc;
	assign saturated              = chain_data[MAX_TERMS].sat;

endmodule

`default_nettype wire

// ----- sim/tb_horner_polynomial_eval_unit.sv -----
`timescale 1ns / 1ps
// tb_horner_polynomial_eval_unit: self-checking bench for the Q16.16 Horner evaluator.
// Depends on hpe_pkg and horner_polynomial_eval_unit; a local predictor models each point.

module tb_horner_polynomial_eval_unit;

	localparam int FRAC       = 16;
	localparam int MAX_DEGREE = 6;
	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
	localparam longint ROUND_BIAS = 64'sd1 <<< (FRAC - 1);

	// Handy Q16.16 values
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_ZERO = 32'sh0000_0000;
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
	localparam logic signed [hpe_pkg::DATA_W-1:0] Q_LSB  = 32'sh0000_0001;

	typedef logic [hpe_pkg::COEFF_REGS-1:0][hpe_pkg::DATA_W-1:0] coeff_set_t;

	typedef struct {
		logic signed [hpe_pkg::DATA_W-1:0] value;
		logic                              sat;
	} poly_result_t;

	// DUT signals; the bench-driven inputs are known from time zero
	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              cfg_wr_en  = 1'b0;
	logic [hpe_pkg::IDX_W-1:0]         cfg_index  = hpe_pkg::REG_DEGREE;
	logic [hpe_pkg::DATA_W-1:0]        cfg_data   = '0;
	logic                              in_valid   = 1'b0;
	logic                              in_ready;
	logic signed [hpe_pkg::DATA_W-1:0] x_value    = '0;
	logic                              out_valid;
	logic                              out_ready  = 1'b1;
	logic signed [hpe_pkg::DATA_W-1:0] poly_value;
	logic                              saturated;

	// Mirror of the programmed polynomial
	logic [hpe_pkg::IDX_W-1:0]         degree_q = '0;
	logic signed [hpe_pkg::DATA_W-1:0] coeff_q [hpe_pkg::COEFF_REGS];

	poly_result_t expected_q [$];
	int  err_cnt     = 0;
	int  stall_left  = 0;
	bit  tx_idle_en  = 1'b1;
	bit  rx_stall_en = 1'b1;

	horner_polynomial_eval_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_value    (x_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.poly_value (poly_value),
		.saturated  (saturated)
	);

	always #6 clk = ~clk;

	initial begin
		for (int k = 0; k < hpe_pkg::COEFF_REGS; k++) coeff_q[k] = '0;
	end

	// Horner's rule with round-half-up, shift and saturation at every step
	function automatic poly_result_t horner_eval(input logic signed [hpe_pkg::DATA_W-1:0] x);
		poly_result_t r;
		longint acc;
		longint prod;
		int top;
		acc   = 0;
		r.sat = 1'b0;
		top   = (int'(degree_q) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_q);
		for (int k = top; k >= 0; k--) begin
			prod = acc * longint'(x);
			prod = (prod + ROUND_BIAS) >>> FRAC;
			if (prod > S32_MAX) begin
				prod  = S32_MAX;
				r.sat = 1'b1;
			end else if (prod < S32_MIN) begin
				prod  = S32_MIN;
				r.sat = 1'b1;
			end
			acc = prod + longint'(coeff_q[k]);
			if (acc > S32_MAX) begin
				acc   = S32_MAX;
				r.sat = 1'b1;
			end else if (acc < S32_MIN) begin
				acc   = S32_MIN;
				r.sat = 1'b1;
			end
		end
		r.value = acc[hpe_pkg::DATA_W-1:0];
		return r;
	endfunction

	// Mix of full-range words, extremes, tiny raw values and values near the origin
	function automatic logic signed [hpe_pkg::DATA_W-1:0] rand_fixed();
		int v;
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return Q_ZERO;
					3: return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
			2: begin
				v = int'($urandom_range(0, 510)) - 255;
				return v;
			end
			default: begin
				v = int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
				return v;
			end
		endcase
	endfunction

	// Receiver: drops out_ready in random stall bursts while rx_stall_en is set
	always @(posedge clk) begin : drive_out_ready
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		poly_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: poly_value %h saturated %b", poly_value, saturated);
				err_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (poly_value !== want.value) begin
					$error("poly_value mismatch: expected %h, actual %h", want.value, poly_value);
					err_cnt++;
				end
				if (saturated !== want.sat) begin
					$error("saturated mismatch: expected %b, actual %b", want.sat, saturated);
					err_cnt++;
				end
			end
		end
	end

	// One point request; valid stays up after acceptance unless a gap follows
	task automatic send_point(input logic signed [hpe_pkg::DATA_W-1:0] x);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value  <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(horner_eval(x));
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain_results();
		if (in_valid) in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Write degree and all seven coefficients; only called with the pipeline empty
	task automatic program_poly(input logic [hpe_pkg::IDX_W-1:0] deg, input coeff_set_t cs);
		cfg_wr_en <= 1'b1;
		cfg_index <= hpe_pkg::REG_DEGREE;
		cfg_data  <= hpe_pkg::DATA_W'(deg);
		@(posedge clk);
		for (int k = 0; k < hpe_pkg::COEFF_REGS; k++) begin
			cfg_index <= hpe_pkg::cfg_reg_t'(hpe_pkg::REG_COEFF_0 + k);
			cfg_data  <= cs[k];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		degree_q = deg;
		for (int k = 0; k < hpe_pkg::COEFF_REGS; k++) coeff_q[k] = cs[k];
	endtask

	// Cleared registers give zero everywhere
	task automatic test_reset_defaults();
		send_point(Q_MAX);
		send_point(Q_MIN);
	endtask

	// p(x) = x across the input range
	task automatic test_identity_and_extremes();
		coeff_set_t cs;
		cs    = '0;
		cs[1] = Q_ONE;
		drain_results();
		program_poly(3'd1, cs);
		send_point(Q_MAX);
		send_point(Q_MIN);
		send_point(Q_ZERO);
		send_point(Q_ONE);
		send_point(-Q_LSB);
	endtask

	// Halfway products round toward plus infinity
	task automatic test_rounding_ties();
		coeff_set_t cs;
		cs    = '0;
		cs[1] = Q_HALF;
		drain_results();
		program_poly(3'd1, cs);
		send_point(Q_LSB);
		send_point(-Q_LSB);
		send_point(32'sd3);
	endtask

	// Coefficients above the degree have no effect
	task automatic test_unused_coefficients();
		coeff_set_t cs;
		cs    = {hpe_pkg::COEFF_REGS{Q_MAX}};
		cs[0] = Q_MIN;
		drain_results();
		program_poly(3'd0, cs);
		send_point(Q_MAX);
		send_point(Q_ONE);
	endtask

	// Product clamp and sum clamp in both directions
	task automatic test_saturation();
		coeff_set_t cs;
		cs    = '0;
		cs[2] = Q_MAX;
		drain_results();
		program_poly(3'd2, cs);
		send_point(Q_MAX);
		send_point(Q_MIN);
		cs    = '0;
		cs[1] = Q_ONE;
		cs[0] = Q_MAX;
		drain_results();
		program_poly(3'd1, cs);
		send_point(Q_ONE);
		cs[0] = Q_MIN;
		drain_results();
		program_poly(3'd1, cs);
		send_point(-Q_ONE);
	endtask

	// Degree 7 acts as degree 6
	task automatic test_degree_clamp();
		coeff_set_t cs;
		cs = {hpe_pkg::COEFF_REGS{Q_ONE}};
		drain_results();
		program_poly(3'd7, cs);
		send_point(Q_ONE);
		send_point(-Q_ONE);
		send_point(Q_HALF);
	endtask

	// Random polynomials, extremes first, with varying idle patterns
	task automatic test_random_phases();
		coeff_set_t cs;
		logic [hpe_pkg::IDX_W-1:0] deg;
		for (int p = 0; p < 10; p++) begin
			drain_results();
			tx_idle_en  = (p % 3 != 2);
			rx_stall_en = (p % 3 != 1);
			case (p)
				0: begin
					deg = 3'd7;
					cs  = {hpe_pkg::COEFF_REGS{Q_MAX}};
				end
				1: begin
					deg = 3'd6;
					cs  = {hpe_pkg::COEFF_REGS{Q_MIN}};
				end
				default: begin
					deg = (p == 2) ? 3'd0 : hpe_pkg::IDX_W'($urandom_range(0, 7));
					for (int k = 0; k < hpe_pkg::COEFF_REGS; k++) cs[k] = rand_fixed();
				end
			endcase
			program_poly(deg, cs);
			for (int i = 0; i < 75; i++) begin
				// hold off mid-phase until the pipeline is empty
				if (p == 4 && i == 35) drain_results();
				send_point(rand_fixed());
			end
		end
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_streaming();
		coeff_set_t cs;
		drain_results();
		tx_idle_en  = 1'b0;
		rx_stall_en = 1'b0;
		for (int k = 0; k < hpe_pkg::COEFF_REGS; k++) cs[k] = rand_fixed();
		program_poly(hpe_pkg::IDX_W'($urandom_range(1, 6)), cs);
		for (int i = 0; i < 150; i++) send_point(rand_fixed());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_identity_and_extremes();
		test_rounding_ties();
		test_unused_coefficients();
		test_saturation();
		test_degree_clamp();
		test_random_phases();
		test_streaming();
		drain_results();
		// keep watching for stray results after the last expected one
		repeat (30) @(posedge clk);
		if (err_cnt == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/hpe_pkg.sv
rtl/hpe_step.sv
rtl/horner_polynomial_eval_unit.sv
sim/tb_horner_polynomial_eval_unit.sv
